>>> rtl/core/pps_pkg.sv
// shared constants, codes and control types for the priority scheduler
package pps_pkg;

    // default sizing
    localparam int MAX_PROCS_DEF  = 16;
    localparam int TIME_WIDTH_DEF = 16;

    // fixed field widths
    localparam int PRI_W    = 8;
    localparam int STATUS_W = 2;

    // item opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO = 2'd2;

    // per-cell control from the sequencer
    typedef struct packed {
        logic load;  // write a new task entry into this cell
        logic upd;   // this cell's task runs for one unit
    } t_cell_ctl;

endpackage

>>> rtl/core/pps_cell.sv
// one task slot of the scheduler chain: holds the entry, forwards the best candidate
module pps_cell #(
    parameter int MAX_PROCS  = pps_pkg::MAX_PROCS_DEF,
    parameter int TIME_WIDTH = pps_pkg::TIME_WIDTH_DEF,
    parameter int IDX        = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pps_pkg::t_cell_ctl            i_ctl,
    input  logic [TIME_WIDTH-1:0]         i_time,
    input  logic [TIME_WIDTH-1:0]         i_ld_arr,
    input  logic [TIME_WIDTH-1:0]         i_ld_burst,
    input  logic [pps_pkg::PRI_W-1:0]     i_ld_pri,
    // candidate from the lower neighbor
    input  logic                          i_found,
    input  logic [$clog2(MAX_PROCS)-1:0]  i_idx,
    input  logic [pps_pkg::PRI_W-1:0]     i_pri,
    input  logic [TIME_WIDTH-1:0]         i_arr,
    input  logic [TIME_WIDTH-1:0]         i_burst,
    input  logic [TIME_WIDTH-1:0]         i_rem,
    input  logic [TIME_WIDTH-1:0]         i_first,
    input  logic                          i_started,
    // candidate to the upper neighbor
    output logic                          o_found,
    output logic [$clog2(MAX_PROCS)-1:0]  o_idx,
    output logic [pps_pkg::PRI_W-1:0]     o_pri,
    output logic [TIME_WIDTH-1:0]         o_arr,
    output logic [TIME_WIDTH-1:0]         o_burst,
    output logic [TIME_WIDTH-1:0]         o_rem,
    output logic [TIME_WIDTH-1:0]         o_first,
    output logic                          o_started
);

    localparam int IW = $clog2(MAX_PROCS);

    logic                      r_loaded;
    logic                      r_started;
    logic [TIME_WIDTH-1:0]     r_arr;
    logic [TIME_WIDTH-1:0]     r_burst;
    logic [pps_pkg::PRI_W-1:0] r_pri;
    logic [TIME_WIDTH-1:0]     r_rem;
    logic [TIME_WIDTH-1:0]     r_first;

    logic                      r_c_found;
    logic [IW-1:0]             r_c_idx;
    logic [pps_pkg::PRI_W-1:0] r_c_pri;
    logic [TIME_WIDTH-1:0]     r_c_arr;
    logic [TIME_WIDTH-1:0]     r_c_burst;
    logic [TIME_WIDTH-1:0]     r_c_rem;
    logic [TIME_WIDTH-1:0]     r_c_first;
    logic                      r_c_started;

    logic ready;
    logic take;

    // this slot is eligible and beats the incoming candidate
    assign ready = r_loaded && (r_arr <= i_time) && (r_rem != '0);
    assign take  = ready && (!i_found || (r_pri < i_pri) ||
                             ((r_pri == i_pri) && (r_arr < i_arr)));

    // valid and started flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded  <= 1'b0;
            r_started <= 1'b0;
            r_c_found <= 1'b0;
        end else begin
            r_c_found <= take || i_found;
            if (i_ctl.load) begin
                r_loaded  <= 1'b1;
                r_started <= 1'b0;
            end else if (i_ctl.upd) begin
                r_started <= 1'b1;
            end
        end
    end

    // task entry
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_arr   <= i_ld_arr;
            r_burst <= i_ld_burst;
            r_pri   <= i_ld_pri;
            r_rem   <= i_ld_burst;
        end else if (i_ctl.upd) begin
            r_rem <= r_rem - 1'b1;
            if (!r_started) begin
                r_first <= i_time;
            end
        end
    end

    // candidate stage toward the next cell
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_c_idx     <= IW'(IDX);
            r_c_pri     <= r_pri;
            r_c_arr     <= r_arr;
            r_c_burst   <= r_burst;
            r_c_rem     <= r_rem;
            r_c_first   <= r_first;
            r_c_started <= r_started;
        end else begin
            r_c_idx     <= i_idx;
            r_c_pri     <= i_pri;
            r_c_arr     <= i_arr;
            r_c_burst   <= i_burst;
            r_c_rem     <= i_rem;
            r_c_first   <= i_first;
            r_c_started <= i_started;
        end
    end

    assign o_found   = r_c_found;
    assign o_idx     = r_c_idx;
    assign o_pri     = r_c_pri;
    assign o_arr     = r_c_arr;
    assign o_burst   = r_c_burst;
    assign o_rem     = r_c_rem;
    assign o_first   = r_c_first;
    assign o_started = r_c_started;

endmodule

>>> rtl/core/preemptive_priority_scheduler_core.sv
// Load beat: result strobe in the cycle after the beat is taken, busy stays low.
// Tick beat: busy while the best candidate ripples one cell per cycle through
// the slot chain, then the result strobe; a new beat is taken only once busy
// has dropped, so the scan length is set by chain length.
// The result is shown for one cycle only; the receiver cannot stall it.
// Synchronous active-low reset empties the table and clears time and counts.
module preemptive_priority_scheduler_core #(
    parameter int MAX_PROCS  = pps_pkg::MAX_PROCS_DEF,
    parameter int TIME_WIDTH = pps_pkg::TIME_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_op,
    input  logic [TIME_WIDTH-1:0]                i_arrival_time,
    input  logic [TIME_WIDTH-1:0]                i_burst_length,
    input  logic [pps_pkg::PRI_W-1:0]            i_task_priority,
    output logic                                 o_valid,
    output logic [pps_pkg::STATUS_W-1:0]         o_status,
    output logic [$clog2(MAX_PROCS+1)-1:0]       o_running_pid,
    output logic [TIME_WIDTH-1:0]                o_time_now,
    output logic                                 o_finished,
    output logic [TIME_WIDTH-1:0]                o_turnaround,
    output logic [TIME_WIDTH-1:0]                o_waiting,
    output logic [TIME_WIDTH-1:0]                o_response_delay,
    output logic                                 o_all_done
);

    localparam int CW = $clog2(MAX_PROCS+1);
    localparam int IW = $clog2(MAX_PROCS);
    localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;
    localparam logic [CW-1:0] CNT_LAST = CW'(MAX_PROCS);
    localparam logic [CW-1:0] CNT_FULL = CW'(MAX_PROCS);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    // sequencer and scheduler state
    logic                      r_state, n_state;
    logic [CW-1:0]             r_cnt, n_cnt;
    logic [TIME_WIDTH-1:0]     r_time, n_time;
    logic [CW-1:0]             r_task_cnt, n_task_cnt;
    logic [CW-1:0]             r_done_cnt, n_done_cnt;

    // result registers
    logic                          r_valid, n_valid;
    logic [pps_pkg::STATUS_W-1:0]  r_status, n_status;
    logic [CW-1:0]                 r_pid, n_pid;
    logic [TIME_WIDTH-1:0]         r_time_now;
    logic                          r_fin, n_fin;
    logic [TIME_WIDTH-1:0]         r_tat, n_tat;
    logic [TIME_WIDTH-1:0]         r_wt, n_wt;
    logic [TIME_WIDTH-1:0]         r_resp, n_resp;
    logic                          r_all_done;

    // candidate chain, element 0 is the empty candidate
    logic                      c_found   [MAX_PROCS+1];
    logic [IW-1:0]             c_idx     [MAX_PROCS+1];
    logic [pps_pkg::PRI_W-1:0] c_pri     [MAX_PROCS+1];
    logic [TIME_WIDTH-1:0]     c_arr     [MAX_PROCS+1];
    logic [TIME_WIDTH-1:0]     c_burst   [MAX_PROCS+1];
    logic [TIME_WIDTH-1:0]     c_rem     [MAX_PROCS+1];
    logic [TIME_WIDTH-1:0]     c_first   [MAX_PROCS+1];
    logic                      c_started [MAX_PROCS+1];

    pps_pkg::t_cell_ctl        cell_ctl  [MAX_PROCS];

    logic                      accept;
    logic                      scan_end;
    logic                      load_en;
    logic [TIME_WIDTH-1:0]     time_inc;
    logic [TIME_WIDTH-1:0]     first_v;
    logic [TIME_WIDTH-1:0]     tat_v;
    logic                      fin_v;

    assign busy     = (r_state == S_SCAN);
    assign accept   = start && !busy;
    assign scan_end = (r_state == S_SCAN) && (r_cnt == CNT_LAST);
    assign load_en  = accept && (i_op == pps_pkg::OP_LOAD) &&
                      (i_burst_length != '0) && (r_task_cnt != CNT_FULL);

    assign c_found[0]   = 1'b0;
    assign c_idx[0]     = '0;
    assign c_pri[0]     = '0;
    assign c_arr[0]     = '0;
    assign c_burst[0]   = '0;
    assign c_rem[0]     = '0;
    assign c_first[0]   = '0;
    assign c_started[0] = 1'b0;

    // row of task cells
    for (genvar i = 0; i < MAX_PROCS; i++) begin : g_cell
        assign cell_ctl[i].load = load_en && (r_task_cnt == CW'(i));
        assign cell_ctl[i].upd  = scan_end && c_found[MAX_PROCS] &&
                                  (c_idx[MAX_PROCS] == IW'(i));

        pps_cell #(
            .MAX_PROCS  (MAX_PROCS),
            .TIME_WIDTH (TIME_WIDTH),
            .IDX        (i)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (cell_ctl[i]),
            .i_time     (r_time),
            .i_ld_arr   (i_arrival_time),
            .i_ld_burst (i_burst_length),
            .i_ld_pri   (i_task_priority),
            .i_found    (c_found[i]),
            .i_idx      (c_idx[i]),
            .i_pri      (c_pri[i]),
            .i_arr      (c_arr[i]),
            .i_burst    (c_burst[i]),
            .i_rem      (c_rem[i]),
            .i_first    (c_first[i]),
            .i_started  (c_started[i]),
            .o_found    (c_found[i+1]),
            .o_idx      (c_idx[i+1]),
            .o_pri      (c_pri[i+1]),
            .o_arr      (c_arr[i+1]),
            .o_burst    (c_burst[i+1]),
            .o_rem      (c_rem[i+1]),
            .o_first    (c_first[i+1]),
            .o_started  (c_started[i+1])
        );
    end

    // winner statistics at the end of the chain
    assign time_inc = (r_time == TIME_MAX) ? r_time : r_time + 1'b1;
    assign first_v  = c_started[MAX_PROCS] ? c_first[MAX_PROCS] : r_time;
    assign fin_v    = (c_rem[MAX_PROCS] == TIME_WIDTH'(1));
    assign tat_v    = time_inc - c_arr[MAX_PROCS];

    // sequencer and result formation
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_time     = r_time;
        n_task_cnt = r_task_cnt;
        n_done_cnt = r_done_cnt;
        n_valid    = 1'b0;
        n_status   = pps_pkg::ST_OK;
        n_pid      = '0;
        n_fin      = 1'b0;
        n_tat      = '0;
        n_wt       = '0;
        n_resp     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_op == pps_pkg::OP_TICK) begin
                        n_state = S_SCAN;
                        n_cnt   = '0;
                    end else begin
                        n_valid = 1'b1;
                        if (i_burst_length == '0) begin
                            n_status = pps_pkg::ST_ZERO;
                        end else if (r_task_cnt == CNT_FULL) begin
                            n_status = pps_pkg::ST_FULL;
                        end else begin
                            n_task_cnt = r_task_cnt + 1'b1;
                        end
                    end
                end
            end
            S_SCAN: begin
                n_cnt = r_cnt + 1'b1;
                if (scan_end) begin
                    n_state = S_IDLE;
                    n_valid = 1'b1;
                    n_time  = time_inc;
                    if (c_found[MAX_PROCS]) begin
                        n_pid = CW'(c_idx[MAX_PROCS]) + 1'b1;
                        if (fin_v) begin
                            n_fin      = 1'b1;
                            n_done_cnt = r_done_cnt + 1'b1;
                            n_tat      = tat_v;
                            n_wt       = (tat_v >= c_burst[MAX_PROCS]) ?
                                         tat_v - c_burst[MAX_PROCS] : '0;
                            n_resp     = first_v - c_arr[MAX_PROCS];
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_time     <= '0;
            r_task_cnt <= '0;
            r_done_cnt <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_time     <= n_time;
            r_task_cnt <= n_task_cnt;
            r_done_cnt <= n_done_cnt;
            r_valid    <= n_valid;
        end
    end

    // result beat payload
    always_ff @(posedge i_clk) begin
        if (n_valid) begin
            r_status   <= n_status;
            r_pid      <= n_pid;
            r_time_now <= n_time;
            r_fin      <= n_fin;
            r_tat      <= n_tat;
            r_wt       <= n_wt;
            r_resp     <= n_resp;
            r_all_done <= (n_done_cnt == n_task_cnt);
        end
    end

    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_running_pid    = r_pid;
    assign o_time_now       = r_time_now;
    assign o_finished       = r_fin;
    assign o_turnaround     = r_tat;
    assign o_waiting        = r_wt;
    assign o_response_delay = r_resp;
    assign o_all_done       = r_all_done;

    // checks
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_state == S_IDLE))
        else $error("result beat while a scan is running");

    a_fin_pid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_fin) |-> (r_pid != '0))
        else $error("completion reported with no running task");

    a_done_le_tasks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done_cnt <= r_task_cnt)
        else $error("more tasks completed than loaded");

    a_tick_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_op == pps_pkg::OP_TICK)) |=> (busy && (r_cnt == '0)))
        else $error("tick beat did not start a scan");

endmodule

>>> tb/sv/tb.sv
// self-checking testbench for the preemptive priority scheduler core
module tb;

    localparam int MAX_PROCS    = pps_pkg::MAX_PROCS_DEF;
    localparam int TIME_W       = pps_pkg::TIME_WIDTH_DEF;
    localparam int PRI_W        = pps_pkg::PRI_W;
    localparam int STATUS_W     = pps_pkg::STATUS_W;
    localparam int PID_W        = $clog2(MAX_PROCS + 1);
    localparam int RANDOM_BEATS = 1800;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    // one result beat as the core presents it
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PID_W-1:0]    pid;
        logic [TIME_W-1:0]   time_now;
        logic                finished;
        logic [TIME_W-1:0]   turnaround;
        logic [TIME_W-1:0]   waiting;
        logic [TIME_W-1:0]   response;
        logic                all_done;
    } t_sched_result;

    // one row of the directed table
    typedef struct packed {
        logic              op;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] burst;
        logic [PRI_W-1:0]  prio;
        logic [7:0]        repeats;
        logic              typed;
        t_sched_result     result;
    } t_stim_row;

    localparam t_sched_result NO_CHECK = '0;
    localparam int N_ROWS = 14;

    // directed beats; typed results only where they are obvious
    localparam t_stim_row DIRECTED [N_ROWS] = '{
        // idle tick on an empty table, all done with nothing loaded
        '{pps_pkg::OP_TICK, 16'h0000, 16'h0000, 8'h00, 8'd1, 1'b1,
          t_sched_result'{pps_pkg::ST_OK, 5'd0, 16'd1, 1'b0, 16'd0, 16'd0, 16'd0, 1'b1}},
        // zero burst is rejected
        '{pps_pkg::OP_LOAD, 16'hFFFF, 16'h0000, 8'hFF, 8'd1, 1'b1,
          t_sched_result'{pps_pkg::ST_ZERO, 5'd0, 16'd1, 1'b0, 16'd0, 16'd0, 16'd0, 1'b1}},
        // pid 1: shortest task at time zero, top priority
        '{pps_pkg::OP_LOAD, 16'h0000, 16'h0001, 8'h00, 8'd1, 1'b1,
          t_sched_result'{pps_pkg::ST_OK, 5'd0, 16'd1, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0}},
        // pid 2: arrives just below the time limit, never ready in this run
        '{pps_pkg::OP_LOAD, 16'hFFF0, 16'd40, 8'h00, 8'd1, 1'b1,
          t_sched_result'{pps_pkg::ST_OK, 5'd0, 16'd1, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0}},
        // pid 3: arrives at the time limit, lowest priority
        '{pps_pkg::OP_LOAD, 16'hFFFF, 16'd3, 8'hFF, 8'd1, 1'b1,
          t_sched_result'{pps_pkg::ST_OK, 5'd0, 16'd1, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0}},
        // pid 1 runs and completes at once
        '{pps_pkg::OP_TICK, 16'h0000, 16'h0000, 8'h00, 8'd1, 1'b1,
          t_sched_result'{pps_pkg::ST_OK, 5'd1, 16'd2, 1'b1, 16'd2, 16'd1, 16'd1, 1'b0}},
        // nothing ready yet
        '{pps_pkg::OP_TICK, 16'h0000, 16'h0000, 8'h00, 8'd1, 1'b1,
          t_sched_result'{pps_pkg::ST_OK, 5'd0, 16'd3, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0}},
        // equal priority and arrival, lower slot wins
        '{pps_pkg::OP_LOAD, 16'd5, 16'd4, 8'd10, 8'd1, 1'b0, NO_CHECK},
        '{pps_pkg::OP_LOAD, 16'd5, 16'd2, 8'd10, 8'd1, 1'b0, NO_CHECK},
        // equal priority, earlier arrival beats a lower slot
        '{pps_pkg::OP_LOAD, 16'd4, 16'd3, 8'd10, 8'd1, 1'b0, NO_CHECK},
        // higher priority arrives later and preempts
        '{pps_pkg::OP_LOAD, 16'd7, 16'd2, 8'd3, 8'd1, 1'b0, NO_CHECK},
        // arrival already in the past, ready at once
        '{pps_pkg::OP_LOAD, 16'd1, 16'd2, 8'd20, 8'd1, 1'b0, NO_CHECK},
        '{pps_pkg::OP_TICK, 16'h0000, 16'h0000, 8'h00, 8'd12, 1'b0, NO_CHECK},
        '{pps_pkg::OP_LOAD, 16'h0000, 16'h0000, 8'h00, 8'd1, 1'b0, NO_CHECK}
    };

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic                     i_op;
    logic [TIME_W-1:0]        i_arrival_time;
    logic [TIME_W-1:0]        i_burst_length;
    logic [PRI_W-1:0]         i_task_priority;
    logic                     o_valid;
    logic [STATUS_W-1:0]      o_status;
    logic [PID_W-1:0]         o_running_pid;
    logic [TIME_W-1:0]        o_time_now;
    logic                     o_finished;
    logic [TIME_W-1:0]        o_turnaround;
    logic [TIME_W-1:0]        o_waiting;
    logic [TIME_W-1:0]        o_response_delay;
    logic                     o_all_done;

    // predictor copy of the task table
    logic [TIME_W-1:0] arr_tab   [MAX_PROCS];
    logic [TIME_W-1:0] burst_tab [MAX_PROCS];
    logic [PRI_W-1:0]  prio_tab  [MAX_PROCS];
    logic [TIME_W-1:0] left_tab  [MAX_PROCS];
    logic [TIME_W-1:0] first_tab [MAX_PROCS];
    bit                started   [MAX_PROCS];
    int                n_tasks;
    int                n_done;
    logic [TIME_W-1:0] now;

    t_sched_result awaited_results[$];
    int            mismatch_cnt;
    int            idle_pct;

    always #1 i_clk = ~i_clk;

    preemptive_priority_scheduler_core u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_op             (i_op),
        .i_arrival_time   (i_arrival_time),
        .i_burst_length   (i_burst_length),
        .i_task_priority  (i_task_priority),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_running_pid    (o_running_pid),
        .o_time_now       (o_time_now),
        .o_finished       (o_finished),
        .o_turnaround     (o_turnaround),
        .o_waiting        (o_waiting),
        .o_response_delay (o_response_delay),
        .o_all_done       (o_all_done)
    );

    // apply one beat to the predicted table and return its result
    function automatic t_sched_result schedule_step(logic op, logic [TIME_W-1:0] arr,
                                                    logic [TIME_W-1:0] bst,
                                                    logic [PRI_W-1:0] pri);
        t_sched_result r;
        bit            found;
        int            best;
        r     = '0;
        found = 1'b0;
        best  = 0;
        if (op == pps_pkg::OP_LOAD) begin
            if (bst == '0) begin
                r.status = pps_pkg::ST_ZERO;
            end else if (n_tasks >= MAX_PROCS) begin
                r.status = pps_pkg::ST_FULL;
            end else begin
                arr_tab[n_tasks]   = arr;
                burst_tab[n_tasks] = bst;
                prio_tab[n_tasks]  = pri;
                left_tab[n_tasks]  = bst;
                started[n_tasks]   = 1'b0;
                n_tasks++;
            end
        end else begin
            // lowest priority value, then earlier arrival, then lower slot
            for (int i = 0; i < n_tasks; i++) begin
                if (arr_tab[i] <= now && left_tab[i] != '0) begin
                    if (!found || prio_tab[i] < prio_tab[best] ||
                        (prio_tab[i] == prio_tab[best] && arr_tab[i] < arr_tab[best])) begin
                        best  = i;
                        found = 1'b1;
                    end
                end
            end
            if (found && !started[best]) begin
                started[best]   = 1'b1;
                first_tab[best] = now;
            end
            if (now != TIME_MAX) now++;
            if (found) begin
                left_tab[best] = left_tab[best] - 1'b1;
                r.pid = PID_W'(best + 1);
                if (left_tab[best] == '0) begin
                    r.finished   = 1'b1;
                    r.turnaround = now - arr_tab[best];
                    r.waiting    = (r.turnaround >= burst_tab[best]) ?
                                   r.turnaround - burst_tab[best] : '0;
                    r.response   = first_tab[best] - arr_tab[best];
                    n_done++;
                end
            end
        end
        r.time_now = now;
        r.all_done = (n_done == n_tasks);
        return r;
    endfunction

    // drive one beat, wait for it to be taken, queue its expected result
    task automatic send_beat(logic op, logic [TIME_W-1:0] arr, logic [TIME_W-1:0] bst,
                             logic [PRI_W-1:0] pri, logic typed, t_sched_result typed_res);
        t_sched_result predicted;
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start           <= 1'b1;
        i_op            <= op;
        i_arrival_time  <= arr;
        i_burst_length  <= bst;
        i_task_priority <= pri;
        do @(posedge i_clk); while (busy);
        predicted = schedule_step(op, arr, bst, pri);
        awaited_results.push_back(typed ? typed_res : predicted);
        @(negedge i_clk);
    endtask

    // hold off until every queued result has come back
    task automatic drain;
        start <= 1'b0;
        @(negedge i_clk);
        while (awaited_results.size() != 0) @(negedge i_clk);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_sched_result got;
        t_sched_result want;
        if (i_rst_n && o_valid) begin
            got = '{o_status, o_running_pid, o_time_now, o_finished, o_turnaround,
                    o_waiting, o_response_delay, o_all_done};
            if (awaited_results.size() == 0) begin
                if (mismatch_cnt < 10)
                    $display("unexpected result beat: pid=%0d time=%0d", got.pid, got.time_now);
                mismatch_cnt++;
            end else begin
                want = awaited_results.pop_front();
                if (got.status !== want.status || got.pid !== want.pid ||
                    got.time_now !== want.time_now || got.finished !== want.finished ||
                    got.turnaround !== want.turnaround || got.waiting !== want.waiting ||
                    got.response !== want.response || got.all_done !== want.all_done) begin
                    if (mismatch_cnt < 10) begin
                        $display("mismatch exp: st=%0d pid=%0d t=%0d fin=%0d tat=%0d wt=%0d rsp=%0d done=%0d",
                                 want.status, want.pid, want.time_now, want.finished,
                                 want.turnaround, want.waiting, want.response, want.all_done);
                        $display("         got: st=%0d pid=%0d t=%0d fin=%0d tat=%0d wt=%0d rsp=%0d done=%0d",
                                 got.status, got.pid, got.time_now, got.finished,
                                 got.turnaround, got.waiting, got.response, got.all_done);
                    end
                    mismatch_cnt++;
                end
            end
        end
    end

    // stimulus
    initial begin
        int                k;
        int                sel;
        int                grp;
        logic [TIME_W-1:0] arr;
        logic [TIME_W-1:0] bst;
        logic [PRI_W-1:0]  pri;
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_op            = pps_pkg::OP_LOAD;
        i_arrival_time  = '0;
        i_burst_length  = '0;
        i_task_priority = '0;
        n_tasks         = 0;
        n_done          = 0;
        now             = '0;
        mismatch_cnt    = 0;
        idle_pct        = 6;
        for (int i = 0; i < MAX_PROCS; i++) begin
            arr_tab[i]   = '0;
            burst_tab[i] = '0;
            prio_tab[i]  = '0;
            left_tab[i]  = '0;
            first_tab[i] = '0;
            started[i]   = 1'b0;
        end
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table
        for (int row = 0; row < N_ROWS; row++) begin
            for (k = 0; k < DIRECTED[row].repeats; k++)
                send_beat(DIRECTED[row].op, DIRECTED[row].arrival, DIRECTED[row].burst,
                          DIRECTED[row].prio, DIRECTED[row].typed, DIRECTED[row].result);
        end
        drain();

        // random beats in three idling phases
        for (k = 0; k < RANDOM_BEATS; k++) begin
            if (k == RANDOM_BEATS / 3) begin
                drain();
                idle_pct = 74;
            end
            if (k == 2 * RANDOM_BEATS / 3) begin
                drain();
                idle_pct = 0;
            end
            sel = $urandom_range(0, 99);
            if (n_tasks < MAX_PROCS && (sel < 2 || (n_tasks - n_done <= 2 && sel < 30))) begin
                // a small group of tasks, mostly arriving soon, few priority levels
                grp = $urandom_range(1, 3);
                repeat (grp) begin
                    arr = ($urandom_range(0, 3) == 0) ? TIME_W'($urandom_range(0, now)) :
                          now + TIME_W'($urandom_range(0, 24));
                    pri = ($urandom_range(0, 3) == 0) ? PRI_W'($urandom_range(0, 255)) :
                          PRI_W'($urandom_range(0, 7));
                    send_beat(pps_pkg::OP_LOAD, arr, TIME_W'($urandom_range(1, 200)), pri,
                              1'b0, NO_CHECK);
                end
            end else if (sel >= 95) begin
                // stray load: zero burst while slots remain, anything once full
                bst = (n_tasks < MAX_PROCS || $urandom_range(0, 2) == 0) ? '0 :
                      TIME_W'($urandom);
                send_beat(pps_pkg::OP_LOAD, TIME_W'($urandom), bst, PRI_W'($urandom),
                          1'b0, NO_CHECK);
            end else begin
                send_beat(pps_pkg::OP_TICK, TIME_W'($urandom), TIME_W'($urandom),
                          PRI_W'($urandom), 1'b0, NO_CHECK);
            end
        end

        // fill the table, then a few edge beats on the full table
        while (n_tasks < MAX_PROCS)
            send_beat(pps_pkg::OP_LOAD, TIME_W'($urandom_range(0, 16'hFF00)),
                      TIME_W'($urandom_range(1, 5)), PRI_W'($urandom), 1'b0, NO_CHECK);
        send_beat(pps_pkg::OP_LOAD, '1, '1, '1, 1'b0, NO_CHECK);
        send_beat(pps_pkg::OP_LOAD, '0, '0, '0, 1'b0, NO_CHECK);
        send_beat(pps_pkg::OP_TICK, '0, '0, '0, 1'b0, NO_CHECK);
        send_beat(pps_pkg::OP_TICK, '1, '1, '1, 1'b0, NO_CHECK);

        drain();
        repeat (MAX_PROCS + 4) @(posedge i_clk);
        if (mismatch_cnt == 0 && awaited_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
